// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the conv1d block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define C1D_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define C1D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/c1d_pkg.sv =====
// ---------------------------------------------------------------------------
// c1d_pkg
// types and fixed field widths for the five-tap sixteen-channel conv1d
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c1d_pkg;

  localparam int IDX_W      = 7;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int CHANNEL_W  = 4;
  localparam int POSITION_W = 12;
  localparam int VALUE_W    = 40;
  localparam int PROD_W     = 32;
  localparam int BIAS_SHIFT = 12;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_LOAD   = 1'b1;

  typedef struct packed {
    logic                       action;
    logic                       chunk_start;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           coef_index;
    logic signed [COEF_W-1:0]   coef_value;
  } item_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0]      channel;
    logic [POSITION_W-1:0]     position;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic take_sample;
    logic take_load;
    logic issue;
    logic load_write;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic advance;
    logic is_load;
    logic fill_full;
    logic idx_in_range;
    logic last_channel;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== hdl/c1d_stream_if.sv =====
// ---------------------------------------------------------------------------
// c1d_stream_if
// valid/ready channel carrying one item of a given payload type
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface c1d_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/c1d_ram.sv =====
// ---------------------------------------------------------------------------
// c1d_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c1d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/c1d_ctrl.sv =====
// ---------------------------------------------------------------------------
// c1d_ctrl
// sequencer: takes items, issues one channel per cycle while the result side is not stalled, runs coefficient loads
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module c1d_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              ready,
  input  c1d_pkg::ctl_sts_t sts,
  output c1d_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LOAD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    ready      = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        ready = sts.advance;
        if (valid && sts.advance) begin
          if (sts.is_load) begin
            cmd.take_load = sts.idx_in_range;
            if (sts.idx_in_range) begin
              state_next = ST_LOAD;
            end
          end else begin
            cmd.take_sample = 1'b1;
            if (sts.fill_full) begin
              cmd.issue = 1'b1;
              if (!sts.last_channel) begin
                state_next = ST_RUN;
              end
            end
          end
        end
      end
      ST_RUN: begin
        if (sts.advance) begin
          cmd.issue = 1'b1;
          if (sts.last_channel) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_write = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `C1D_ASSERT_NEXT(a_run_ends, clk, rst,
    (state == ST_RUN) && sts.advance && sts.last_channel, state == ST_IDLE,
    "channel sweep did not return to idle after the last channel")

  `C1D_ASSERT_IMPL(a_load_not_issue, clk, rst,
    cmd.load_write, !cmd.issue && !ready,
    "load sequence overlaps channel issue or input acceptance")

endmodule

`default_nettype wire

// ===== hdl/c1d_datapath.sv =====
// ---------------------------------------------------------------------------
// c1d_datapath
// sample window, banked coefficient store, multiply and sum pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module c1d_datapath #(
  parameter int TAPS         = 5,
  parameter int OUT_CHANNELS = 16,
  parameter int MAX_CHUNK    = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  c1d_pkg::ctl_cmd_t cmd,
  output c1d_pkg::ctl_sts_t sts,
  input  c1d_pkg::item_t    item,
  output c1d_pkg::result_t  result,
  output logic              result_valid,
  input  logic              result_ready
);

  localparam int SW          = c1d_pkg::SAMPLE_W;
  localparam int CW          = c1d_pkg::COEF_W;
  localparam int IW          = c1d_pkg::IDX_W;
  localparam int PW          = c1d_pkg::PROD_W;
  localparam int VW          = c1d_pkg::VALUE_W;
  localparam int CHW         = c1d_pkg::CHANNEL_W;
  localparam int POW         = c1d_pkg::POSITION_W;
  localparam int CH_W        = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int POS_W       = $clog2(MAX_CHUNK);
  localparam int FILL_W      = $clog2(TAPS);
  localparam int BANK_W      = $clog2(TAPS + 1);
  localparam int BIAS_BASE   = OUT_CHANNELS * TAPS;
  localparam int STORE_DEPTH = OUT_CHANNELS * (TAPS + 1);
  localparam int DIV_SH      = 2 * IW;
  localparam int RECIP       = ((1 << DIV_SH) + TAPS - 1) / TAPS;
  localparam int QW          = 3 * IW;

  // window, fill and position
  logic signed [SW-1:0] window [TAPS-1];
  logic [FILL_W-1:0]    fill;
  logic [FILL_W-1:0]    fill_eff;
  logic [POS_W-1:0]     position;
  logic [POS_W-1:0]     pos_eff;
  logic [POS_W-1:0]     pos_sat;
  logic [POS_W-1:0]     cur_pos;
  logic [POS_W-1:0]     pos_now;
  logic                 fill_full;

  // channel sweep
  logic [CH_W-1:0]      ch;
  logic                 last_channel;
  logic signed [SW-1:0] op_reg [TAPS];
  logic signed [SW-1:0] ops_now [TAPS];
  logic                 advance;

  // coefficient load
  logic                 ld_bias;
  logic [QW-1:0]        ld_prod;
  logic [IW-1:0]        ld_quo;
  logic [IW-1:0]        ld_tap;
  logic signed [CW-1:0] ld_value;
  logic [BANK_W-1:0]    wr_bank;
  logic [CH_W-1:0]      wr_addr;
  logic [CW-1:0]        bank_rdata [TAPS+1];

  // pipeline stages
  logic                 s1_valid;
  logic [CH_W-1:0]      s1_ch;
  logic [POS_W-1:0]     s1_pos;
  logic                 s1_last;
  logic signed [SW-1:0] s1_ops [TAPS];
  logic                 s2_valid;
  logic [CH_W-1:0]      s2_ch;
  logic [POS_W-1:0]     s2_pos;
  logic                 s2_last;
  logic signed [PW-1:0] s2_prod [TAPS];
  logic signed [VW-1:0] s2_bias;
  logic signed [VW-1:0] acc;

  assign advance      = !result_valid || result_ready;
  assign fill_eff     = item.chunk_start ? '0 : fill;
  assign pos_eff      = item.chunk_start ? '0 : position;
  assign fill_full    = (fill_eff == FILL_W'(TAPS - 1));
  assign pos_sat      = (pos_eff == POS_W'(MAX_CHUNK - 1)) ? pos_eff : pos_eff + 1'b1;
  assign last_channel = (ch == CH_W'(OUT_CHANNELS - 1));
  assign pos_now      = cmd.take_sample ? pos_eff : cur_pos;

  // weight index split into tap and channel by reciprocal multiplication
  assign ld_bias = (32'(item.coef_index) >= BIAS_BASE);
  assign ld_prod = QW'(item.coef_index) * QW'(RECIP);
  assign ld_quo  = IW'(ld_prod >> DIV_SH);
  assign ld_tap  = item.coef_index - ld_quo * IW'(TAPS);

  always_comb begin
    sts              = '0;
    sts.advance      = advance;
    sts.is_load      = (item.action == c1d_pkg::ACTION_LOAD);
    sts.fill_full    = fill_full;
    sts.idx_in_range = (32'(item.coef_index) < STORE_DEPTH);
    sts.last_channel = last_channel;
  end

  // oldest sample meets tap 0, the new sample meets the last tap
  always_comb begin
    for (int k = 0; k < TAPS - 1; k++) begin
      ops_now[k] = cmd.take_sample ? window[k] : op_reg[k];
    end
    ops_now[TAPS-1] = cmd.take_sample ? item.sample : op_reg[TAPS-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      position <= '0;
      ch       <= '0;
    end else begin
      if (cmd.take_sample) begin
        if (fill_full) begin
          fill     <= fill_eff;
          position <= pos_sat;
        end else begin
          fill     <= fill_eff + 1'b1;
          position <= pos_eff;
        end
      end
      if (cmd.issue) begin
        ch <= last_channel ? '0 : ch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      for (int k = 0; k < TAPS - 2; k++) begin
        window[k] <= window[k+1];
      end
      window[TAPS-2] <= item.sample;
      for (int k = 0; k < TAPS; k++) begin
        op_reg[k] <= ops_now[k];
      end
      cur_pos <= pos_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_load) begin
      wr_bank  <= ld_bias ? BANK_W'(TAPS) : BANK_W'(ld_tap);
      wr_addr  <= ld_bias ? CH_W'(32'(item.coef_index) - BIAS_BASE) : CH_W'(ld_quo);
      ld_value <= item.coef_value;
    end
  end

  // one bank per tap plus one for the biases, each indexed by channel
  for (genvar b = 0; b < TAPS + 1; b++) begin : g_bank
    c1d_ram #(
      .WIDTH (CW),
      .DEPTH (OUT_CHANNELS)
    ) u_bank (
      .clk   (clk),
      .we    (cmd.load_write && (wr_bank == BANK_W'(b))),
      .waddr (wr_addr),
      .wdata (ld_value),
      .re    (cmd.issue),
      .raddr (ch),
      .rdata (bank_rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= cmd.issue;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ch   <= ch;
      s1_pos  <= pos_now;
      s1_last <= last_channel;
      for (int k = 0; k < TAPS; k++) begin
        s1_ops[k]  <= ops_now[k];
        s2_prod[k] <= s1_ops[k] * $signed(bank_rdata[k]);
      end
      s2_bias <= VW'($signed(bank_rdata[TAPS])) <<< c1d_pkg::BIAS_SHIFT;
      s2_ch   <= s1_ch;
      s2_pos  <= s1_pos;
      s2_last <= s1_last;
      result.channel  <= CHW'(s2_ch);
      result.position <= POW'(s2_pos);
      result.value    <= acc;
      result.last     <= s2_last;
    end
  end

  always_comb begin
    acc = s2_bias;
    for (int k = 0; k < TAPS; k++) begin
      acc = acc + VW'(s2_prod[k]);
    end
  end

  `C1D_ASSERT_IMPL(a_issue_advance, clk, rst, cmd.issue, advance,
    "channel issued while the result pipeline is stalled")

  `C1D_ASSERT_NEXT(a_stage_flow, clk, rst, s1_valid && advance, s2_valid,
    "product stage lost an item")

  `C1D_ASSERT_NEXT(a_warmup_quiet, clk, rst, cmd.take_sample && !fill_full, !s1_valid,
    "warm-up sample produced a channel issue")

endmodule

`default_nettype wire

// ===== hdl/conv1d_five_tap_sixteen_channel.sv =====
// A sample with a full window shows its channel 0 result after the s1, s2 and result registers.
// A new sample is taken only once the sweep over all channels of the last one is done, one channel
// per cycle through the shared multiply and sum pipeline while results do not stall; warm-up samples start no sweep.
// Coefficient loads split the index on acceptance and write the store in the next cycle.
// Reset is synchronous and clears window fill, position and pipeline valids;
// the coefficient store is undefined until loaded.
// ---------------------------------------------------------------------------
// conv1d_five_tap_sixteen_channel
// single input channel 1-d convolution, five taps, sixteen biased outputs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module conv1d_five_tap_sixteen_channel #(
  parameter int TAPS         = 5,
  parameter int OUT_CHANNELS = 16,
  parameter int MAX_CHUNK    = 4096
) (
  input  logic         clk,
  input  logic         rst,
  c1d_stream_if.sink   items,
  c1d_stream_if.source results
);

  c1d_pkg::ctl_cmd_t cmd;
  c1d_pkg::ctl_sts_t sts;

  c1d_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (items.valid),
    .ready (items.ready),
    .sts   (sts),
    .cmd   (cmd)
  );

  c1d_datapath #(
    .TAPS         (TAPS),
    .OUT_CHANNELS (OUT_CHANNELS),
    .MAX_CHUNK    (MAX_CHUNK)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .item         (items.data),
    .result       (results.data),
    .result_valid (results.valid),
    .result_ready (results.ready)
  );

endmodule

`default_nettype wire

// ===== bench/conv1d_five_tap_sixteen_channel_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conv1d_five_tap_sixteen_channel_checker
// Watches the item and result channels of the five-tap, sixteen-channel
// conv1d. It keeps its own coefficient store, sample window, fill count and
// position, and works out the sixteen biased sums of every sample it sees
// accepted with a full window. Each accepted result is checked field by
// field against the oldest sum still due. It hands its failure count and
// the number of sums still due to the bench top.
// ---------------------------------------------------------------------------

module conv1d_five_tap_sixteen_channel_checker
  import c1d_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  c1d_stream_if item_ch,
  c1d_stream_if result_ch,
  output int    failures,
  output int    pending
);

  localparam int TAPS        = 5;
  localparam int CHANNELS    = 16;
  localparam int BIAS_BASE   = CHANNELS * TAPS;
  localparam int STORE_WORDS = BIAS_BASE + CHANNELS;
  localparam int MAX_POS     = 4095;

  logic signed [COEF_W-1:0]   coef_mem [STORE_WORDS];
  logic signed [SAMPLE_W-1:0] window [TAPS-1];
  logic [2:0]                 fill;
  logic [POSITION_W-1:0]      pos;
  result_t                    sums_due [$];

  task automatic convolve_item(input item_t it);
    result_t            r;
    logic signed [63:0] acc;
    if (it.action == ACTION_LOAD) begin
      if (it.coef_index < STORE_WORDS) coef_mem[it.coef_index] = it.coef_value;
    end else begin
      if (it.chunk_start) begin
        fill = '0;
        pos  = '0;
      end
      if (fill >= TAPS - 1) begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          acc = coef_mem[BIAS_BASE + ch];
          acc = acc <<< BIAS_SHIFT;
          for (int k = 0; k < TAPS - 1; k++) begin
            acc = acc + window[k] * coef_mem[ch * TAPS + k];
          end
          acc = acc + it.sample * coef_mem[ch * TAPS + TAPS - 1];
          r.channel  = CHANNEL_W'(ch);
          r.position = pos;
          r.value    = acc[VALUE_W-1:0];
          r.last     = (ch == CHANNELS - 1);
          sums_due.push_back(r);
        end
        if (pos != MAX_POS) pos = pos + 1'b1;
      end else begin
        fill = fill + 1'b1;
      end
      for (int k = 0; k < TAPS - 2; k++) window[k] = window[k + 1];
      window[TAPS-2] = it.sample;
    end
  endtask

  task automatic check_sum(input result_t got);
    result_t want;
    if (sums_due.size() == 0) begin
      $error("unexpected result: channel %0d position %0d value %0d",
             got.channel, got.position, got.value);
      failures++;
    end else begin
      want = sums_due.pop_front();
      if (got.channel !== want.channel) begin
        $error("channel mismatch: expected %0d, actual %0d", want.channel, got.channel);
        failures++;
      end
      if (got.position !== want.position) begin
        $error("position mismatch: expected %0d, actual %0d", want.position, got.position);
        failures++;
      end
      if (got.value !== want.value) begin
        $error("value mismatch: expected %0d, actual %0d", want.value, got.value);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      failures = 0;
      fill     = '0;
      pos      = '0;
      for (int i = 0; i < STORE_WORDS; i++) coef_mem[i] = '0;
      for (int k = 0; k < TAPS - 1; k++) window[k] = '0;
      sums_due.delete();
      pending <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) convolve_item(item_ch.data);
      if (result_ch.valid && result_ch.ready) check_sum(result_ch.data);
      pending <= sums_due.size();
    end
  end

endmodule

// ===== bench/conv1d_five_tap_sixteen_channel_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conv1d_five_tap_sixteen_channel_test
// Bench top for the five-tap, sixteen-channel conv1d. It fills the whole
// coefficient store first, runs a short directed sequence over the sample
// and weight extremes, warm-up, chunk restarts and ignored loads, then
// random chunks with loads mixed in and a final stretch with no idling.
// Both sides idle in random bursts. The checker beside the block does all
// prediction and comparison.
// ---------------------------------------------------------------------------

module conv1d_five_tap_sixteen_channel_test;
  import c1d_pkg::*;

  localparam int CHANNELS     = 16;
  localparam int TAPS         = 5;
  localparam int BIAS_BASE    = CHANNELS * TAPS;
  localparam int STORE_WORDS  = BIAS_BASE + CHANNELS;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 4_000_000;

  logic clk;
  logic rst;
  bit   quiet;
  int   items_sent;
  int   stall_left;
  int   cycles;
  int   failures;
  int   pending;

  c1d_stream_if #(.data_t(item_t))   items_ch ();
  c1d_stream_if #(.data_t(result_t)) results_ch ();

  conv1d_five_tap_sixteen_channel u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  conv1d_five_tap_sixteen_channel_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .item_ch   (items_ch),
    .result_ch (results_ch),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // result side stalls in bursts
  initial begin
    results_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        results_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: rand_word = 16'h7FFF;
      1: rand_word = 16'h8000;
      2: rand_word = 16'h0000;
      3: rand_word = 16'hFFFF;
      default: rand_word = 16'($urandom);
    endcase
  endfunction

  function automatic item_t make_sample(input logic start, input logic [15:0] word);
    item_t it;
    it.action      = ACTION_SAMPLE;
    it.chunk_start = start;
    it.sample      = word;
    it.coef_index  = IDX_W'($urandom);
    it.coef_value  = 16'($urandom);
    return it;
  endfunction

  function automatic item_t make_load(input logic [IDX_W-1:0] idx, input logic [15:0] word);
    item_t it;
    it.action      = ACTION_LOAD;
    it.chunk_start = 1'($urandom);
    it.sample      = 16'($urandom);
    it.coef_index  = idx;
    it.coef_value  = word;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      items_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.data  <= it;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    if (!(it.action == ACTION_LOAD && it.coef_index >= STORE_WORDS)) items_sent++;
  endtask

  task automatic wait_for_drain();
    items_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly whole chunks from a chunk start, with loads and strays mixed in
  task automatic send_random_sequence();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 24);
      send_item(make_sample(1'b1, rand_word()));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0)
          send_item(make_load(IDX_W'($urandom_range(0, STORE_WORDS - 1)), rand_word()));
        send_item(make_sample(1'b0, rand_word()));
      end
    end else if (pick < 85) begin
      send_item(make_load(IDX_W'($urandom_range(0, STORE_WORDS - 1)), rand_word()));
    end else if (pick < 92) begin
      send_item(make_load(IDX_W'($urandom_range(STORE_WORDS, 127)), rand_word()));
    end else begin
      repeat ($urandom_range(1, 5)) send_item(make_sample(1'b0, rand_word()));
    end
  endtask

  initial begin
    logic [15:0] word;
    int          target;
    quiet = 1'b0;
    items_sent = 0;
    rst <= 1'b1;
    items_ch.valid <= 1'b0;
    items_ch.data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // whole store: channel 0 all max, channel 1 all min
    for (int idx = 0; idx < STORE_WORDS; idx++) begin
      if (idx < TAPS || idx == BIAS_BASE) word = 16'h7FFF;
      else if (idx < 2 * TAPS || idx == BIAS_BASE + 1) word = 16'h8000;
      else word = rand_word();
      send_item(make_load(IDX_W'(idx), word));
    end

    // ignored loads past the store
    send_item(make_load(IDX_W'(STORE_WORDS), 16'h7FFF));
    send_item(make_load(7'h7F, 16'h8000));

    // warm-up from reset, then the extremes
    repeat (5) send_item(make_sample(1'b0, 16'h7FFF));
    repeat (5) send_item(make_sample(1'b0, 16'h8000));
    send_item(make_sample(1'b0, 16'h0000));
    send_item(make_sample(1'b0, 16'hFFFF));
    // load in the middle of a chunk leaves the window alone
    send_item(make_load(IDX_W'(3), 16'h1234));
    send_item(make_sample(1'b0, 16'h0001));

    // chunk restarts, back to back and mid warm-up
    send_item(make_sample(1'b1, 16'h8000));
    repeat (4) send_item(make_sample(1'b0, rand_word()));
    send_item(make_sample(1'b1, 16'h7FFF));
    send_item(make_sample(1'b0, rand_word()));
    send_item(make_sample(1'b1, rand_word()));
    send_item(make_sample(1'b1, rand_word()));
    repeat (4) send_item(make_sample(1'b0, rand_word()));

    target = items_sent + 80;
    while (items_sent < target) send_random_sequence();

    wait_for_drain();

    quiet = 1'b1;
    target = items_sent + 40;
    while (items_sent < target) send_random_sequence();
    quiet = 1'b0;

    target = items_sent + 50;
    while (items_sent < target) send_random_sequence();

    quiet = 1'b1;
    target = items_sent + 25;
    while (items_sent < target) send_random_sequence();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
